FILE: src/frns_pkg.sv
// Package: shared constants, types and helper functions for the neighbor search block.
`default_nettype none

package frns_pkg;

    localparam int MAX_POINTS  = 64;
    localparam int COORD_BITS  = 16;

    localparam int IDX_W       = $clog2(MAX_POINTS);
    localparam int FIELD_W     = 16;
    localparam int SLOT_W      = 6;
    localparam int CUT_W       = 16;
    localparam int PIU_W       = 7;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    // distance pipeline: abs diff, square, sum/compare
    localparam int PIPE_DEPTH  = 3;
    localparam int PIPE_CNT_W  = $clog2(PIPE_DEPTH);
    localparam int CNT_W       = (IDX_W > PIPE_CNT_W) ? IDX_W : PIPE_CNT_W;
    localparam int DIFF_W      = COORD_BITS + 1;
    localparam int SQ_W        = 2 * DIFF_W;
    localparam int SUM_W       = SQ_W + 2;
    localparam int LIM_W       = 2 * CUT_W;
    localparam int CMP_W       = (SUM_W > LIM_W) ? SUM_W : LIM_W;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_POINTS = CFG_IDX_W'(1);

    localparam logic [CUT_W-1:0] CUTOFF_RESET = CUT_W'(8192);
    localparam logic [PIU_W-1:0] POINTS_RESET = PIU_W'(64);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_SCAN,
        ST_DRAIN,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic                      op;
        logic [SLOT_W-1:0]         slot;
        logic signed [FIELD_W-1:0] pos_x;
        logic signed [FIELD_W-1:0] pos_y;
        logic signed [FIELD_W-1:0] pos_z;
    } in_item_t;

    typedef struct packed {
        logic                      found;
        logic [SLOT_W-1:0]         neighbor_slot;
        logic signed [FIELD_W-1:0] neighbor_x;
        logic signed [FIELD_W-1:0] neighbor_y;
        logic signed [FIELD_W-1:0] neighbor_z;
        logic                      last;
    } out_item_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } point_t;

    // neighbor candidate leaving the distance pipeline
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        point_t           pt;
    } cand_t;

    // sign-extend the 16-bit field, then wrap to the stored width
    function automatic logic signed [COORD_BITS-1:0] load_coord(
        input logic signed [FIELD_W-1:0] v
    );
        logic [COORD_BITS+FIELD_W-1:0] ext;
        ext = {{COORD_BITS{v[FIELD_W-1]}}, v};
        return ext[COORD_BITS-1:0];
    endfunction

    // stored value sign-extended, then cut to the 16-bit field
    function automatic logic signed [FIELD_W-1:0] out_coord(
        input logic signed [COORD_BITS-1:0] c
    );
        logic [COORD_BITS+FIELD_W-1:0] ext;
        ext = {{FIELD_W{c[COORD_BITS-1]}}, c};
        return ext[FIELD_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: src/frns_cell.sv
// Point cell: holds one stored point, loads it directly or takes its neighbor's on a shift.
`default_nettype none

module frns_cell
    import frns_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   shift_en,
    input  wire logic   load_en,
    input  wire point_t shift_in,
    input  wire point_t load_in,
    output point_t      pos
);

    point_t pos_reg;

    always_ff @(posedge aclk) begin
        if (load_en) begin
            pos_reg <= load_in;
        end else if (shift_en) begin
            pos_reg <= shift_in;
        end
    end

    assign pos = pos_reg;

endmodule

`default_nettype wire

FILE: src/frns_dist.sv
// Distance pipeline: squared distance of a scanned point to the source against cutoff squared.
`default_nettype none

module frns_dist
    import frns_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire logic [IDX_W-1:0] in_idx,
    input  wire point_t           in_pt,
    input  wire point_t           src_pt,
    input  wire logic [CUT_W-1:0] cutoff,
    output logic                  cand_valid,
    output cand_t                 cand
);

    function automatic logic [DIFF_W-1:0] abs_diff(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b
    );
        logic [DIFF_W-1:0] d;
        d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        return d[DIFF_W-1] ? (~d + DIFF_W'(1)) : d;
    endfunction

    logic [LIM_W-1:0]  limit_reg;

    logic              v1_reg;
    logic              eq1_reg;
    cand_t             c1_reg;
    logic [DIFF_W-1:0] ax1_reg, ay1_reg, az1_reg;

    logic              v2_reg;
    logic              eq2_reg;
    cand_t             c2_reg;
    logic [SQ_W-1:0]   sx2_reg, sy2_reg, sz2_reg;

    logic              v3_reg;
    cand_t             c3_reg;

    logic [SUM_W-1:0]  sum;
    logic              in_range;

    always_comb begin
        sum      = SUM_W'(sx2_reg) + SUM_W'(sy2_reg) + SUM_W'(sz2_reg);
        in_range = CMP_W'(sum) < CMP_W'(limit_reg);
    end

    always_ff @(posedge aclk) begin
        limit_reg <= LIM_W'(cutoff) * LIM_W'(cutoff);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            // duplicates of the source never count as neighbors
            v3_reg <= v2_reg && !eq2_reg && in_range;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            eq1_reg    <= (in_pt == src_pt);
            c1_reg.idx <= in_idx;
            c1_reg.pt  <= in_pt;
            ax1_reg    <= abs_diff(in_pt.x, src_pt.x);
            ay1_reg    <= abs_diff(in_pt.y, src_pt.y);
            az1_reg    <= abs_diff(in_pt.z, src_pt.z);

            eq2_reg    <= eq1_reg;
            c2_reg     <= c1_reg;
            sx2_reg    <= SQ_W'(ax1_reg) * SQ_W'(ax1_reg);
            sy2_reg    <= SQ_W'(ay1_reg) * SQ_W'(ay1_reg);
            sz2_reg    <= SQ_W'(az1_reg) * SQ_W'(az1_reg);

            c3_reg     <= c2_reg;
        end
    end

    assign cand_valid = v3_reg;
    assign cand       = c3_reg;

endmodule

`default_nettype wire

FILE: src/fixed_radius_neighbor_search.sv
// Top level: ring of point cells, query sequencer, distance pipeline and result output stage.
// Load: written straight into the addressed cell; next item the cycle after.
// Query: one ring turn (ST_FIND) picks up the source, a second (ST_SCAN) feeds the pipeline,
// then ST_DRAIN empties the pipeline and ST_FLUSH closes with the last record; no new item is
// taken until the query is back in ST_IDLE, and any result channel stall holds the sequence.
// Reset clears control, cutoff_radius 8192, points_in_use 64; points undefined until loaded.
`default_nettype none

module fixed_radius_neighbor_search
    import frns_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_item_t              s_data,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_data,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    function automatic out_item_t make_rec(
        input logic  found,
        input cand_t c,
        input logic  last
    );
        out_item_t r;
        r.found         = found;
        r.neighbor_slot = SLOT_W'(c.idx);
        r.neighbor_x    = out_coord(c.pt.x);
        r.neighbor_y    = out_coord(c.pt.y);
        r.neighbor_z    = out_coord(c.pt.z);
        r.last          = last;
        return r;
    endfunction

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [IDX_W-1:0]   src_idx_reg;
    point_t             src_reg;
    logic [CUT_W-1:0]   cutoff_reg;
    logic [PIU_W-1:0]   points_reg;

    logic               m_valid_reg;
    out_item_t          m_data_reg;
    logic               hold_valid_reg;
    cand_t              hold_reg;

    logic               en;
    logic               in_fire;
    logic               load_fire;
    logic               shift_en;
    logic               scan_valid;
    point_t             load_pt;
    point_t             cell_pos [MAX_POINTS];
    point_t             head;
    logic               cand_valid;
    cand_t              cand;
    cand_t              empty_cand;

    // ring shift, sequencer and pipeline advance only when the output register can take a record
    assign en        = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign in_fire   = s_valid && s_ready;
    assign load_fire = in_fire && (s_data.op == OP_LOAD);
    assign cfg_ready = 1'b1;
    assign head      = cell_pos[0];
    assign shift_en  = en && ((state_reg == ST_FIND) || (state_reg == ST_SCAN));
    assign scan_valid = (state_reg == ST_SCAN) && (PIU_W'(cnt_reg) < points_reg);

    always_comb begin
        load_pt.x = load_coord(s_data.pos_x);
        load_pt.y = load_coord(s_data.pos_y);
        load_pt.z = load_coord(s_data.pos_z);
        empty_cand = '0;
    end

    // ring: cell i takes cell i+1, the last takes the head
    for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
        frns_cell u_cell (
            .aclk     (aclk),
            .shift_en (shift_en),
            .load_en  (load_fire && (s_data.slot == SLOT_W'(i))),
            .shift_in (cell_pos[(i + 1) % MAX_POINTS]),
            .load_in  (load_pt),
            .pos      (cell_pos[i])
        );
    end

    frns_dist u_dist (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (scan_valid),
        .in_idx     (cnt_reg[IDX_W-1:0]),
        .in_pt      (head),
        .src_pt     (src_reg),
        .cutoff     (cutoff_reg),
        .cand_valid (cand_valid),
        .cand       (cand)
    );

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire && (s_data.op == OP_QUERY)) begin
                    cnt_next = '0;
                    if (int'(s_data.slot) < MAX_POINTS) begin
                        state_next = ST_FIND;
                    end else begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FIND, ST_SCAN: begin
                if (en) begin
                    if (cnt_reg == CNT_W'(MAX_POINTS - 1)) begin
                        cnt_next   = '0;
                        state_next = (state_reg == ST_FIND) ? ST_SCAN : ST_DRAIN;
                    end else begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
            end
            ST_DRAIN: begin
                if (en) begin
                    if (cnt_reg == CNT_W'(PIPE_DEPTH - 1)) begin
                        cnt_next   = '0;
                        state_next = ST_FLUSH;
                    end else begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
            end
            ST_FLUSH: begin
                if (en) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cutoff_reg <= CUTOFF_RESET;
            points_reg <= POINTS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_CUTOFF: cutoff_reg <= cfg_data[CUT_W-1:0];
                REG_POINTS: points_reg <= cfg_data[PIU_W-1:0];
                default: ;
            endcase
        end
    end

    // source slot and its point, picked off the head while the ring turns
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            src_idx_reg <= s_data.slot[IDX_W-1:0];
        end
        if ((state_reg == ST_FIND) && en && (cnt_reg == CNT_W'(src_idx_reg))) begin
            src_reg <= head;
        end
    end

    // one candidate is held back until the next one or the end shows whether it is last
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            hold_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (en && cand_valid) begin
                if (hold_valid_reg) begin
                    m_valid_reg <= 1'b1;
                end
                hold_valid_reg <= 1'b1;
            end
            if (en && (state_reg == ST_FLUSH)) begin
                m_valid_reg    <= 1'b1;
                hold_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en && cand_valid) begin
            if (hold_valid_reg) begin
                m_data_reg <= make_rec(1'b1, hold_reg, 1'b0);
            end
            hold_reg <= cand;
        end
        if (en && (state_reg == ST_FLUSH)) begin
            if (hold_valid_reg) begin
                m_data_reg <= make_rec(1'b1, hold_reg, 1'b1);
            end else begin
                m_data_reg <= make_rec(1'b0, empty_cand, 1'b1);
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire
